// ===== rtl/core/madelung_lattice_sum_core_assert.svh =====
// Assertion macros for the lattice sum core checker.
`ifndef MADELUNG_LATTICE_SUM_CORE_ASSERT_SVH
`define MADELUNG_LATTICE_SUM_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define MLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lattice sum check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define MLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lattice sum check failed");

`endif

// ===== rtl/core/mls_pkg.sv =====
package mls_pkg;

  localparam int unsigned SideW  = 7;
  localparam int unsigned CoordW = 6;
  localparam int unsigned D2W    = 16;
  localparam int unsigned TermW  = 25;
  localparam int unsigned SumW   = 48;

  typedef struct packed {
    logic              operation;
    logic [SideW-1:0]  lattice_side;
    logic [CoordW-1:0] ion_x;
    logic [CoordW-1:0] ion_y;
    logic [CoordW-1:0] ion_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [SumW-1:0] energy_sum;
    logic                   coordinate_error;
  } out_beat_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic              flat;
    logic [SideW-1:0]  side;
    logic [CoordW-1:0] ix;
    logic [CoordW-1:0] iy;
    logic [CoordW-1:0] iz;
    logic              err;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/core/mls_front.sv =====
module mls_front #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  mls_pkg::in_beat_t in_beat_i,
  output mls_pkg::job_t     job_o
);
  import mls_pkg::*;

  localparam int unsigned SideLim = (MAX_SIDE > 127) ? 127 : MAX_SIDE;

  logic [SideW-1:0] side;

  always_comb begin
    side = (in_beat_i.lattice_side > SideW'(SideLim)) ? SideW'(SideLim)
                                                     : in_beat_i.lattice_side;
    job_o.flat = in_beat_i.operation;
    job_o.side = side;
    job_o.ix   = in_beat_i.ion_x;
    job_o.iy   = in_beat_i.ion_y;
    job_o.iz   = in_beat_i.ion_z;
    job_o.err  = ({1'b0, in_beat_i.ion_x} >= side) || ({1'b0, in_beat_i.ion_y} >= side) ||
                 ({1'b0, in_beat_i.ion_z} >= side);
  end

endmodule

// ===== rtl/core/mls_queue.sv =====
module mls_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mls_pkg::job_t    job_i,
  input  logic             pop_i,
  output mls_pkg::job_t    job_o,
  output mls_pkg::q_stat_t stat_o
);
  import mls_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign job_o        = mem_q[rd_q];
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

endmodule

// ===== rtl/core/mls_term.sv =====
module mls_term (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mls_pkg::D2W-1:0]    d2_i,
  output logic                       done_o,
  output logic [mls_pkg::TermW-1:0]  term_o
);
  import mls_pkg::*;

  // round(2^24/sqrt(d2)): restoring 2^50/d2, one bit a cycle, then bitwise isqrt.
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_SQRT = 2'd2;

  logic [1:0]     ph_q, ph_d;
  logic [5:0]     cnt_q, cnt_d;
  logic [D2W-1:0] dv_q, dv_d;
  logic [D2W-1:0] rem_q, rem_d;
  logic [51:0]    v_q, v_d, r_q, r_d, b_q, b_d;
  logic           done_q, done_d;
  logic [TermW-1:0] term_q, term_d;
  logic [D2W:0]   trial;
  logic [51:0]    rb;
  logic           ge;

  always_comb begin
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    dv_d   = dv_q;
    rem_d  = rem_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    done_d = 1'b0;
    term_d = term_q;
    trial  = {rem_q, (cnt_q == 6'd50)};
    ge     = (trial >= {1'b0, dv_q});
    rb     = r_q + b_q;
    case (ph_q)
      P_IDLE: begin
        if (start_i) begin
          ph_d  = P_DIV;
          cnt_d = 6'd50;
          dv_d  = d2_i;
          rem_d = '0;
          v_d   = '0;
        end
      end
      P_DIV: begin
        rem_d = ge ? D2W'(trial - {1'b0, dv_q}) : trial[D2W-1:0];
        v_d   = {v_q[50:0], ge};
        if (cnt_q == 6'd0) begin
          ph_d  = P_SQRT;
          cnt_d = 6'd25;
          r_d   = '0;
          b_d   = 52'd1 << 50;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      P_SQRT: begin
        if (v_q >= rb) begin
          v_d = v_q - rb;
          r_d = (r_q >> 1) + b_q;
        end else begin
          r_d = r_q >> 1;
        end
        b_d = b_q >> 2;
        if (cnt_q == 6'd0) begin
          ph_d   = P_IDLE;
          done_d = 1'b1;
          term_d = TermW'((r_d[25:0] + 26'd1) >> 1);
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      default: ph_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= P_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
    v_q    <= v_d;
    r_q    <= r_d;
    b_q    <= b_d;
    term_q <= term_d;
  end

  assign done_o = done_q;
  assign term_o = term_q;

endmodule

// ===== rtl/core/mls_back.sv =====
module mls_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mls_pkg::q_stat_t   q_stat_i,
  input  mls_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mls_pkg::out_beat_t out_beat_o
);
  import mls_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PT   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       st_q, st_d;
  job_t             job_q, job_d;
  logic [SideW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [SumW-1:0] acc_q, acc_d;
  logic             ov_q, ov_d;
  out_beat_t        ob_q, ob_d;
  logic [SideW-1:0] pz, dx, dy, dz, last;
  logic [D2W-1:0]   d2;
  logic             skip, neg, t_start, t_done, adv;
  logic [TermW-1:0] term;

  mls_term u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(t_start),
    .d2_i   (d2),
    .done_o (t_done),
    .term_o (term)
  );

  always_comb begin
    last = job_q.side - SideW'(1);
    pz   = job_q.flat ? {1'b0, job_q.iz} : z_q;
    dx   = (x_q > {1'b0, job_q.ix}) ? x_q - {1'b0, job_q.ix} : {1'b0, job_q.ix} - x_q;
    dy   = (y_q > {1'b0, job_q.iy}) ? y_q - {1'b0, job_q.iy} : {1'b0, job_q.iy} - y_q;
    dz   = (pz  > {1'b0, job_q.iz}) ? pz  - {1'b0, job_q.iz} : {1'b0, job_q.iz} - pz;
    d2   = (D2W'(dx) * D2W'(dx)) + (D2W'(dy) * D2W'(dy)) + (D2W'(dz) * D2W'(dz));
    skip = ((x_q == '0) && (y_q == '0) && (z_q == '0)) || (d2 == '0);
    neg  = x_q[0] ^ y_q[0] ^ pz[0] ^ job_q.ix[0] ^ job_q.iy[0] ^ job_q.iz[0];
  end

  always_comb begin
    st_d    = st_q;
    job_d   = job_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    acc_d   = acc_q;
    ov_d    = ov_q;
    ob_d    = ob_q;
    pop_o   = 1'b0;
    t_start = 1'b0;
    adv     = 1'b0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (q_stat_i.valid) begin
          pop_o = 1'b1;
          job_d = job_i;
          x_d   = '0;
          y_d   = '0;
          z_d   = '0;
          acc_d = '0;
          st_d  = job_i.err ? S_DONE : S_PT;
        end
      end
      S_PT: begin
        if (skip) begin
          adv = 1'b1;
        end else begin
          t_start = 1'b1;
          st_d    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (t_done) begin
          acc_d = neg ? acc_q - SumW'(term) : acc_q + SumW'(term);
          adv   = 1'b1;
          st_d  = S_PT;
        end
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d                  = 1'b1;
          ob_d.energy_sum       = job_q.err ? '0 : acc_q;
          ob_d.coordinate_error = job_q.err;
          st_d                  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
    if (adv) begin
      if (z_q == last) begin
        z_d = '0;
        if (y_q == last) begin
          y_d = '0;
          if (x_q == last) st_d = S_DONE;
          else x_d = x_q + SideW'(1);
        end else begin
          y_d = y_q + SideW'(1);
        end
      end else begin
        z_d = z_q + SideW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    acc_q <= acc_d;
    ob_q  <= ob_d;
  end

  assign out_valid_o = ov_q;
  assign out_beat_o  = ob_q;

endmodule

// ===== rtl/core/madelung_lattice_sum_core.sv =====
// Per item: each summed pair waits on the term unit and each skipped point is only stepped
//   past, behind the queue and the output register; an item with a bad coordinate skips the walk.
// Throughput: one item at a time; the single 1/sqrt unit (51 divide + 26 root steps)
//   sets the rate, and the two-entry job queue keeps the input open meanwhile.
// Reset: rst_ni is asynchronous, active low; it empties the queue, idles the sequencer
//   and drops out_valid_o. Payload registers are not reset.
module madelung_lattice_sum_core #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mls_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mls_pkg::out_beat_t out_beat_o
);
  import mls_pkg::*;

  job_t    job_in, job_out;
  q_stat_t q_stat;
  logic    push, pop;

  // Front: clamp the side to MAX_SIDE (at most 127) and flag coordinates outside the cube.
  mls_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .in_beat_i(in_beat_i),
    .job_o    (job_in)
  );

  // Input beat is taken whenever the queue has room.
  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  mls_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .job_i (job_in),
    .pop_i (pop),
    .job_o (job_out),
    .stat_o(q_stat)
  );

  // Back: walks x, y, z; each non-skipped point goes through the term unit and
  // its signed term is added to the accumulator; the result sits in an output
  // register so the next job can start while it waits.
  mls_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule

// ===== rtl/core/mls_checker.sv =====
`include "madelung_lattice_sum_core_assert.svh"

module mls_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mls_pkg::in_beat_t  in_beat_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mls_pkg::out_beat_t out_beat_o
);
  import mls_pkg::*;

  logic [2:0] top_bits;
  assign top_bits = out_beat_o.energy_sum[SumW-1:SumW-3];

  `MLS_ASSERT_NEXT(a_in_hold_beat, in_valid_i && in_stall_o, in_valid_i && $stable(in_beat_i))
  `MLS_ASSERT_NEXT(a_out_hold_valid, out_valid_o && out_stall_i, out_valid_o)
  `MLS_ASSERT_NEXT(a_out_hold_beat, out_valid_o && out_stall_i, $stable(out_beat_o))
  `MLS_ASSERT_NOW(a_err_zero, out_valid_o && out_beat_o.coordinate_error, out_beat_o.energy_sum == '0)
  `MLS_ASSERT_NOW(a_sum_range, out_valid_o, top_bits == 3'b000 || top_bits == 3'b111)

endmodule

bind madelung_lattice_sum_core mls_checker u_mls_checker (.*);

// ===== dv/madelung_lattice_sum_checker.sv =====
module madelung_lattice_sum_checker
  import mls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_beat_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_beat_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LimitSide = 64;
  localparam logic signed [63:0] SumHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SumLo = -SumHi - 64'sd1;

  out_beat_t expected_sums[$];
  int        fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_sums.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // round(2^24 / sqrt(d2))
  function automatic logic [63:0] recip_dist(logic [63:0] d2);
    logic [63:0] u;
    u = int_sqrt((64'd1 << 50) / d2);
    return (u + 64'd1) >> 1;
  endfunction

  function automatic out_beat_t lattice_energy(in_beat_t b);
    out_beat_t            res;
    int                   n;
    int                   dx, dy, dz, pz;
    logic [63:0]          d2, t;
    logic signed [63:0]   acc;
    n   = int'(b.lattice_side);
    acc = '0;
    if (n > LimitSide) n = LimitSide;
    res = '0;
    if (b.ion_x >= n || b.ion_y >= n || b.ion_z >= n) begin
      res.coordinate_error = 1'b1;
      return res;
    end
    for (int x = 0; x < n; x++)
      for (int y = 0; y < n; y++)
        for (int z = 0; z < n; z++) begin
          if (x == 0 && y == 0 && z == 0) continue;
          if (x == b.ion_x && y == b.ion_y && z == b.ion_z) continue;
          pz = b.operation ? int'(b.ion_z) : z;
          dx = x - int'(b.ion_x);
          dy = y - int'(b.ion_y);
          dz = pz - int'(b.ion_z);
          d2 = 64'(dx * dx + dy * dy + dz * dz);
          if (d2 == 0) continue;
          t = recip_dist(d2);
          if (((dx + dy + dz) & 1) != 0) acc = acc - $signed(t);
          else acc = acc + $signed(t);
        end
    if (acc > SumHi) acc = SumHi;
    if (acc < SumLo) acc = SumLo;
    res.energy_sum = acc[SumW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && in_valid_i && !in_stall_i)
      expected_sums.push_back(lattice_energy(in_beat_i));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_beat_i), 64'd0);
      end else begin
        want = expected_sums.pop_front();
        if (out_beat_i.energy_sum !== want.energy_sum)
          report_mismatch("energy_sum", 64'(out_beat_i.energy_sum), 64'(want.energy_sum));
        if (out_beat_i.coordinate_error !== want.coordinate_error)
          report_mismatch("coordinate_error", 64'(out_beat_i.coordinate_error),
                          64'(want.coordinate_error));
      end
    end
  end

endmodule

// ===== dv/madelung_lattice_sum_core_tb.sv =====
module madelung_lattice_sum_core_tb;
  import mls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Well-formed sides above 9 are the slowest jobs, so the stall watchdog allows for side 10.
  localparam int WatchdogLimit = 400000;
  localparam int RandomBeats   = 80;
  localparam int QuietTail     = 12;
  localparam int HoldCycles    = 600;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;
  int        fail_count;
  int        pending;
  bit        quiet;

  madelung_lattice_sum_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  madelung_lattice_sum_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Offer one beat; hold it until a rising edge sees no stall.
  task automatic send_beat(in_beat_t b);
    bit s;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_beat  <= b;
    forever begin
      #1 s = in_stall;
      @(posedge clk_i);
      if (!s) break;
      @(negedge clk_i);
    end
  endtask

  // Random gap before some beats, none in the quiet tail.
  task automatic maybe_gap();
    int k;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 5);
      repeat (k) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
    end
  endtask

  function automatic in_beat_t mk(bit op, int side, int x, int y, int z);
    in_beat_t b;
    b.operation    = op;
    b.lattice_side = side[SideW-1:0];
    b.ion_x        = x[CoordW-1:0];
    b.ion_y        = y[CoordW-1:0];
    b.ion_z        = z[CoordW-1:0];
    return b;
  endfunction

  // Mostly small well-formed cubes, some bad coordinates over the full 6-bit range.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int n;
    b.operation = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(0, 63);
      b.lattice_side = n[SideW-1:0];
      b.ion_x = CoordW'($urandom_range(0, 63));
      b.ion_y = CoordW'($urandom_range(0, 63));
      b.ion_z = CoordW'($urandom_range(0, 63));
      case ($urandom_range(0, 2))
        0: b.ion_x = CoordW'($urandom_range(n, 63));
        1: b.ion_y = CoordW'($urandom_range(n, 63));
        default: b.ion_z = CoordW'($urandom_range(n, 63));
      endcase
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(2, 6);
      b.lattice_side = n[SideW-1:0];
      b.ion_x = CoordW'($urandom_range(0, n - 1));
      b.ion_y = CoordW'($urandom_range(0, n - 1));
      b.ion_z = CoordW'($urandom_range(0, n - 1));
    end
    return b;
  endfunction

  // Receiver: long hold-off at the start to back up the queue, then random bursts.
  initial begin
    int k;
    out_stall = 1'b1;
    @(posedge rst_ni);
    repeat (HoldCycles) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (k - 1) @(negedge clk_i);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles without any accepted beat.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= WatchdogLimit) begin
        $display("madelung_lattice_sum_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_beat_t directed[$];
    in_valid  = 1'b0;
    in_beat   = '0;
    quiet     = 1'b0;
    rst_ni    = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Bad coordinates first: fast beats that fill the queue during the hold-off.
    directed.push_back(mk(0, 0, 0, 0, 0));    // side zero: every coordinate bad
    directed.push_back(mk(1, 2, 2, 0, 0));
    directed.push_back(mk(0, 3, 0, 3, 1));
    directed.push_back(mk(1, 4, 1, 1, 63));
    directed.push_back(mk(0, 32, 63, 63, 63));
    directed.push_back(mk(1, 63, 62, 0, 63));
    directed.push_back(mk(0, 1, 0, 0, 0));    // single point, only the origin
    directed.push_back(mk(1, 1, 0, 0, 0));
    directed.push_back(mk(0, 2, 0, 0, 0));    // ion on the origin
    directed.push_back(mk(1, 2, 0, 0, 0));
    directed.push_back(mk(0, 2, 1, 1, 1));
    directed.push_back(mk(1, 2, 1, 1, 1));
    directed.push_back(mk(0, 3, 1, 1, 1));
    directed.push_back(mk(1, 3, 2, 0, 1));
    directed.push_back(mk(0, 5, 4, 4, 4));
    directed.push_back(mk(1, 5, 0, 4, 2));
    directed.push_back(mk(0, 10, 9, 9, 9));   // largest well-formed cube in the run
    directed.push_back(mk(1, 10, 0, 9, 5));
    directed.push_back(mk(0, 7, 3, 5, 6));
    foreach (directed[i]) begin
      maybe_gap();
      send_beat(directed[i]);
    end

    for (int i = 0; i < RandomBeats; i++) begin
      if (i >= RandomBeats - QuietTail) quiet = 1'b1;
      maybe_gap();
      send_beat(random_beat());
    end
    @(negedge clk_i);
    in_valid  <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("madelung_lattice_sum_core_tb: PASS");
    else
      $display("madelung_lattice_sum_core_tb: FAIL");
    $finish;
  end

endmodule
